// ===== hdl/length_prefixed_frame_parser_assert.svh =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser assertion macros
// Clocked assertion helpers used by the parser core; they expect
// clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// Property holds in the same cycle as its antecedent.
`define LPFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Property holds in the cycle after its antecedent.
`define LPFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lpfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser package
// Types and constants shared by the parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 64;
    localparam int EXTRA_W     = 4;

    localparam logic [BYTE_W-1:0]  LEN_CODE_EXT16 = 8'd254;
    localparam logic [BYTE_W-1:0]  LEN_CODE_EXT64 = 8'd255;
    localparam logic [EXTRA_W-1:0] EXT16_BYTES    = 4'd2;
    localparam logic [EXTRA_W-1:0] EXT64_BYTES    = 4'd8;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        PH_OPCODE  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_EXTLEN  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // Input register contents handed to the parse stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_stage_t;

endpackage

// ===== hdl/lpfp_if.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser channels
// Valid/ready channels for the byte stream and for the parse results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfp_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  frame_opcode;
    logic [63:0] frame_length;
    logic [7:0]  payload_byte;
    logic        frame_last;

    modport source (output valid, output item_kind, output frame_opcode,
                    output frame_length, output payload_byte, output frame_last,
                    input ready);
    modport sink (input valid, input item_kind, input frame_opcode,
                  input frame_length, input payload_byte, input frame_last,
                  output ready);
endinterface

// ===== hdl/lpfp_in_stage.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser input stage
// Registers each accepted stream byte ahead of the parse stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfp_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    lpfp_in_if.sink              stream,
    input  logic                 advance,
    output lpfp_pkg::byte_stage_t stage
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [lpfp_pkg::BYTE_W-1:0]     data_reg;
    logic                            take;

    assign stream.ready = !valid_reg || advance;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= stream.in_byte;
        end
    end

    assign stage = '{valid: valid_reg, data: data_reg};

endmodule

// ===== hdl/lpfp_parse_core.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser core
// Phase machine that decodes opcode and length prefixes, counts payload
// bytes and loads the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_assert.svh"

module lpfp_parse_core #(
    parameter int LENGTH_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpfp_pkg::byte_stage_t stage,
    output logic                  advance,
    lpfp_out_if.source            result
);

    localparam int LW = lpfp_pkg::FRAME_LEN_W;
    localparam logic [LW-1:0] LEN_LIMIT = {LW{1'b1}} >> (LW - LENGTH_WIDTH);

    lpfp_pkg::phase_t                 phase_reg, phase_next;
    logic [lpfp_pkg::BYTE_W-1:0]      opcode_reg, opcode_next;
    logic [lpfp_pkg::EXTRA_W-1:0]     extra_reg, extra_next;
    logic [lpfp_pkg::EXTRA_W-1:0]     extra_dec;
    logic [LW-1:0]                    acc_reg, acc_next;
    logic [LENGTH_WIDTH-1:0]          left_reg, left_next;

    logic                             out_valid_reg, out_valid_next;
    logic                             kind_reg, kind_next;
    logic [lpfp_pkg::BYTE_W-1:0]      out_opcode_reg, out_opcode_next;
    logic [LW-1:0]                    out_len_reg, out_len_next;
    logic [lpfp_pkg::BYTE_W-1:0]      out_byte_reg, out_byte_next;
    logic                             last_reg, last_next;

    logic [lpfp_pkg::BYTE_W-1:0]      b;
    logic [LW-1:0]                    hdr_raw;
    logic [LW-1:0]                    hdr_len;
    logic                             pay_last;

    assign b       = stage.data;
    assign advance = !out_valid_reg || result.ready;

    // Short form takes the byte as is; extended form shifts it in.
    assign hdr_raw   = (phase_reg == lpfp_pkg::PH_LENGTH) ? LW'(b) : {acc_reg[LW-9:0], b};
    assign hdr_len   = (hdr_raw > LEN_LIMIT) ? LEN_LIMIT : hdr_raw;
    assign extra_dec = (extra_reg != '0) ? extra_reg - 1'b1 : extra_reg;
    assign pay_last  = left_reg <= LENGTH_WIDTH'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        extra_next      = extra_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        kind_next       = kind_reg;
        out_opcode_next = out_opcode_reg;
        out_len_next    = out_len_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;

        if (advance && stage.valid)
        begin
            case (phase_reg)
                lpfp_pkg::PH_OPCODE:
                begin
                    opcode_next = b;
                    acc_next    = '0;
                    left_next   = '0;
                    extra_next  = '0;
                    phase_next  = lpfp_pkg::PH_LENGTH;
                end
                lpfp_pkg::PH_LENGTH, lpfp_pkg::PH_EXTLEN:
                begin
                    if (phase_reg == lpfp_pkg::PH_LENGTH && b == lpfp_pkg::LEN_CODE_EXT16)
                    begin
                        acc_next   = '0;
                        extra_next = lpfp_pkg::EXT16_BYTES;
                        phase_next = lpfp_pkg::PH_EXTLEN;
                    end
                    else if (phase_reg == lpfp_pkg::PH_LENGTH &&
                             b == lpfp_pkg::LEN_CODE_EXT64)
                    begin
                        acc_next   = '0;
                        extra_next = lpfp_pkg::EXT64_BYTES;
                        phase_next = lpfp_pkg::PH_EXTLEN;
                    end
                    else if (phase_reg == lpfp_pkg::PH_EXTLEN && extra_dec != '0)
                    begin
                        acc_next   = hdr_raw;
                        extra_next = extra_dec;
                    end
                    else
                    begin
                        // Header complete: emit it and open the payload, or go back to the opcode for a zero length.
                        if (phase_reg == lpfp_pkg::PH_EXTLEN)
                        begin
                            extra_next = extra_dec;
                        end
                        acc_next        = hdr_len;
                        out_valid_next  = 1'b1;
                        kind_next       = lpfp_pkg::KIND_HEADER;
                        out_opcode_next = opcode_reg;
                        out_len_next    = hdr_len;
                        out_byte_next   = '0;
                        last_next       = (hdr_len == '0);
                        if (hdr_len == '0)
                        begin
                            phase_next = lpfp_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            left_next  = hdr_len[LENGTH_WIDTH-1:0];
                            phase_next = lpfp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = lpfp_pkg::KIND_PAYLOAD;
                    out_opcode_next = opcode_reg;
                    out_len_next    = acc_reg;
                    out_byte_next   = b;
                    last_next       = pay_last;
                    if (left_reg != '0)
                    begin
                        left_next = left_reg - 1'b1;
                    end
                    if (pay_last)
                    begin
                        left_next  = '0;
                        phase_next = lpfp_pkg::PH_OPCODE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lpfp_pkg::PH_OPCODE;
            opcode_reg    <= '0;
            extra_reg     <= '0;
            acc_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            extra_reg     <= extra_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        out_opcode_reg <= out_opcode_next;
        out_len_reg    <= out_len_next;
        out_byte_reg   <= out_byte_next;
        last_reg       <= last_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.item_kind    = kind_reg;
    assign result.frame_opcode = out_opcode_reg;
    assign result.frame_length = out_len_reg;
    assign result.payload_byte = out_byte_reg;
    assign result.frame_last   = last_reg;

    `LPFP_ASSERT_NOW(a_payload_count_live, phase_reg == lpfp_pkg::PH_PAYLOAD,
        left_reg != '0, "payload phase with no bytes left")
    `LPFP_ASSERT_NOW(a_extlen_count_live, phase_reg == lpfp_pkg::PH_EXTLEN,
        extra_reg != '0, "extended length phase with no bytes left")
    `LPFP_ASSERT_NOW(a_length_saturated, out_valid_reg,
        out_len_reg <= LEN_LIMIT, "frame length above limit")
    `LPFP_ASSERT_NEXT(a_last_returns, advance && stage.valid &&
        phase_reg == lpfp_pkg::PH_PAYLOAD && pay_last,
        phase_reg == lpfp_pkg::PH_OPCODE && out_valid_reg && last_reg,
        "last payload byte did not close the frame")

endmodule

// ===== hdl/length_prefixed_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser
// Splits a byte stream into frames of opcode, length prefix and payload.
// ---------------------------------------------------------------------------
// Takes one stream byte per cycle and, with no back-pressure on the result
// channel, sustains one byte per cycle indefinitely; each result is
// registered (the input register loads at the accepting edge, the result
// register loads from it when the parse core advances).
// Each byte is handled in a single pass of the phase machine in the parse
// core, which updates the length accumulator or the payload down-counter
// once per cycle unless the result channel stalls. Opcode and length-prefix
// bytes give no result; the header result follows the last prefix byte, and
// every payload byte gives one result, the final one marked last. Lengths
// above 2^LENGTH_WIDTH-1 saturate to that value. stream.ready follows
// result.ready combinationally once input and result registers are occupied.
`timescale 1ns / 1ps

module length_prefixed_frame_parser #(
    parameter int LENGTH_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lpfp_in_if.sink    stream,
    lpfp_out_if.source result
);

    lpfp_pkg::byte_stage_t stage;
    logic                  advance;

    lpfp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .advance (advance),
        .stage   (stage)
    );

    lpfp_parse_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parse_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed frame parser testbench
// Feeds framed byte streams (short, 16-bit and 64-bit length prefixes, zero
// length and long payloads) through the parser under random source gaps and
// sink stalls. Checks every header and payload result against a predicted
// result queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          LEN_W        = 64;
    localparam logic [63:0] LEN_MAX      = {64{1'b1}} >> (64 - LEN_W);
    localparam int          ITEM_TARGET  = 1000;
    localparam int          DRAIN_POINT  = 500;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          SETTLE_TICKS = 8;
    localparam int          REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_COIN,
        SINK_CHOKE
    } sink_mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic [63:0] length;
        logic [7:0]  data;
        logic        last;
    } frame_result_t;

    logic clk;
    logic rst_n;

    lpfp_in_if  stream_ch ();
    lpfp_out_if result_ch ();

    length_prefixed_frame_parser #(
        .LENGTH_WIDTH(LEN_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_ch),
        .result(result_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Stream bytes waiting to be sent, and results the parser still owes.
    logic [7:0]    byte_backlog[$];
    frame_result_t frames_expected[$];

    // Predicted parser state.
    lpfp_pkg::phase_t prs_phase;
    logic [7:0]       prs_opcode;
    logic [3:0]       prs_ext_left;
    logic [63:0]      prs_length;
    logic [63:0]      prs_remaining;

    int         fault_count;
    int         bytes_sent;
    int         burst_left;
    int         gap_left;
    int         idle_cycles;
    sink_mode_t ready_mode;
    int         ready_span;
    frame_result_t predicted;
    frame_result_t observed;
    frame_result_t wanted;

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    function automatic void append_byte(input logic [7:0] v);
        byte_backlog.insert(byte_backlog.size(), v);
    endfunction

    function automatic void close_header(output frame_result_t r);
        if (prs_length > LEN_MAX)
        begin
            prs_length = LEN_MAX;
        end
        r.kind   = lpfp_pkg::KIND_HEADER;
        r.opcode = prs_opcode;
        r.length = prs_length;
        r.data   = '0;
        r.last   = (prs_length == 0);
        if (prs_length == 0)
        begin
            prs_phase = lpfp_pkg::PH_OPCODE;
        end
        else
        begin
            prs_remaining = prs_length;
            prs_phase     = lpfp_pkg::PH_PAYLOAD;
        end
    endfunction

    // Advance the predicted parser by one stream byte; return 1 with a result.
    function automatic bit advance_parser(input logic [7:0] b, output frame_result_t r);
        bit produced;
        produced = 1'b0;
        r = '0;
        case (prs_phase)
            lpfp_pkg::PH_OPCODE:
            begin
                prs_opcode    = b;
                prs_length    = '0;
                prs_remaining = '0;
                prs_ext_left  = '0;
                prs_phase     = lpfp_pkg::PH_LENGTH;
            end
            lpfp_pkg::PH_LENGTH:
            begin
                if (b == lpfp_pkg::LEN_CODE_EXT16 || b == lpfp_pkg::LEN_CODE_EXT64)
                begin
                    prs_length   = '0;
                    prs_ext_left = (b == lpfp_pkg::LEN_CODE_EXT16) ?
                                   lpfp_pkg::EXT16_BYTES : lpfp_pkg::EXT64_BYTES;
                    prs_phase    = lpfp_pkg::PH_EXTLEN;
                end
                else
                begin
                    prs_length = {56'd0, b};
                    close_header(r);
                    produced = 1'b1;
                end
            end
            lpfp_pkg::PH_EXTLEN:
            begin
                prs_length = {prs_length[55:0], b};
                if (prs_ext_left != 0)
                begin
                    prs_ext_left--;
                end
                if (prs_ext_left == 0)
                begin
                    close_header(r);
                    produced = 1'b1;
                end
            end
            default:
            begin
                r.kind   = lpfp_pkg::KIND_PAYLOAD;
                r.opcode = prs_opcode;
                r.length = prs_length;
                r.data   = b;
                r.last   = (prs_remaining <= 1);
                if (prs_remaining > 0)
                begin
                    prs_remaining--;
                end
                if (r.last)
                begin
                    prs_remaining = '0;
                    prs_phase     = lpfp_pkg::PH_OPCODE;
                end
                produced = 1'b1;
            end
        endcase
        return produced;
    endfunction

    task automatic queue_frame(input logic [7:0] op, input len_form_t form,
                               input logic [63:0] len, input int body);
        append_byte(op);
        case (form)
            FORM_SHORT:
            begin
                append_byte(len[7:0]);
            end
            FORM_EXT16:
            begin
                append_byte(lpfp_pkg::LEN_CODE_EXT16);
                append_byte(len[15:8]);
                append_byte(len[7:0]);
            end
            default:
            begin
                append_byte(lpfp_pkg::LEN_CODE_EXT64);
                for (int i = 7; i >= 0; i--)
                begin
                    append_byte(len[8*i +: 8]);
                end
            end
        endcase
        for (int i = 0; i < body; i++)
        begin
            append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Source side: bursts of items separated by random gaps, with a pause at DRAIN_POINT until all owed results are in.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stream_ch.valid   <= 1'b0;
            stream_ch.in_byte <= '0;
            prs_phase     = lpfp_pkg::PH_OPCODE;
            prs_opcode    = '0;
            prs_ext_left  = '0;
            prs_length    = '0;
            prs_remaining = '0;
            bytes_sent    = 0;
            burst_left    = $urandom_range(1, 40);
            gap_left      = 0;
        end
        else
        begin
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (advance_parser(stream_ch.in_byte, predicted))
                begin
                    frames_expected.insert(frames_expected.size(), predicted);
                end
                void'(byte_backlog.pop_front());
                bytes_sent++;
            end
            if (stream_ch.valid && !stream_ch.ready)
            begin
                // hold the offered item until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                stream_ch.valid <= 1'b0;
            end
            else if (bytes_sent == DRAIN_POINT && frames_expected.size() != 0)
            begin
                // hold off until the parser has delivered everything owed
                stream_ch.valid <= 1'b0;
            end
            else if (byte_backlog.size() == 0)
            begin
                stream_ch.valid <= 1'b0;
            end
            else
            begin
                stream_ch.valid   <= 1'b1;
                stream_ch.in_byte <= byte_backlog[0];
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 64);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Sink side: check each result and stall on a pattern of its own.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_mode = SINK_FREE;
            ready_span = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                observed.kind   = result_ch.item_kind;
                observed.opcode = result_ch.frame_opcode;
                observed.length = result_ch.frame_length;
                observed.data   = result_ch.payload_byte;
                observed.last   = result_ch.frame_last;
                if (frames_expected.size() == 0)
                begin
                    note_fault($sformatf("unexpected result kind=%0d op=%02h len=%0d data=%02h last=%0d",
                        observed.kind, observed.opcode, observed.length, observed.data,
                        observed.last));
                end
                else
                begin
                    wanted = frames_expected.pop_front();
                    if (observed.kind !== wanted.kind || observed.opcode !== wanted.opcode
                        || observed.length !== wanted.length || observed.data !== wanted.data
                        || observed.last !== wanted.last)
                    begin
                        note_fault($sformatf({"expected kind=%0d op=%02h len=%0d data=%02h last=%0d,",
                            " got kind=%0d op=%02h len=%0d data=%02h last=%0d"},
                            wanted.kind, wanted.opcode, wanted.length, wanted.data, wanted.last,
                            observed.kind, observed.opcode, observed.length, observed.data,
                            observed.last));
                    end
                end
            end
            if (ready_span == 0)
            begin
                ready_mode = sink_mode_t'($urandom_range(0, 2));
                ready_span = $urandom_range(4, 40);
            end
            else
            begin
                ready_span--;
            end
            case (ready_mode)
                SINK_FREE:  result_ch.ready <= 1'b1;
                SINK_COIN:  result_ch.ready <= 1'($urandom_range(0, 1));
                default:    result_ch.ready <= (ready_span % 6 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int        pick;
        logic [63:0] len;
        len_form_t form;

        rst_n             = 1'b0;
        stream_ch.valid   = 1'b0;
        stream_ch.in_byte = '0;
        result_ch.ready   = 1'b0;
        fault_count       = 0;
        idle_cycles       = 0;

        // Directed: zero-length short frame, one-byte frame with extreme bytes,
        // non-minimal 16-bit zero length, 16-bit length with 00/FF payload,
        // non-minimal 64-bit length with one payload byte.
        queue_frame(8'h00, FORM_SHORT, 64'd0, 0);
        append_byte(8'hFF);
        append_byte(8'h01);
        append_byte(8'hFF);
        queue_frame(8'h5A, FORM_EXT16, 64'd0, 0);
        queue_frame(8'hA5, FORM_EXT16, 64'd2, 0);
        append_byte(8'h00);
        append_byte(8'hFF);
        queue_frame(8'h3C, FORM_EXT64, 64'd1, 1);

        while (byte_backlog.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                form = FORM_SHORT;
                case ($urandom_range(0, 9))
                    0:       len = 64'd253;
                    1:       len = 64'd0;
                    2:       len = 64'($urandom_range(200, 253));
                    default: len = 64'($urandom_range(0, 24));
                endcase
            end
            else if (pick < 85)
            begin
                form = FORM_EXT16;
                case ($urandom_range(0, 9))
                    0:       len = 64'($urandom_range(253, 300));
                    1:       len = 64'd0;
                    default: len = 64'($urandom_range(0, 40));
                endcase
            end
            else
            begin
                form = FORM_EXT64;
                len  = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(0, 40));
            end
            queue_frame(8'($urandom_range(0, 255)), form, len, int'(len));
        end
        // Close with a frame of the largest length; only its first bytes are sent.
        queue_frame(8'hC3, FORM_EXT64, LEN_MAX, 6);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_backlog.size() != 0 || frames_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);

        if (frames_expected.size() != 0)
        begin
            note_fault($sformatf("%0d results never arrived", frames_expected.size()));
        end
        if (fault_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
